### rtl/esd_pkg.sv
// Shared types and constants for the edge sort, deduplicate and index block.
package esd_pkg;

  localparam int MAX_OPS_DEF     = 256;
  localparam int VERTEX_BITS_DEF = 10;
  localparam int SLOTS_PER_OP    = 7;

  localparam int CMD_W  = 3;
  localparam int OPI_W  = 8;
  localparam int SLOT_W = 3;
  localparam int EIDX_W = 11;
  localparam int VTX_W  = 10;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD      = 3'd0,
    CMD_FINISH    = 3'd1,
    CMD_READ_SLOT = 3'd2,
    CMD_SET_SHORT = 3'd3,
    CMD_CLR_SHORT = 3'd4,
    CMD_READ_EDGE = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_BCLR, S_L_A, S_L_B, S_L_C, S_L_D,
    S_PFX_A, S_PFX_B, S_FCLR, S_Q_A, S_Q_B, S_Q_C
  } state_t;

  typedef enum logic [1:0] {
    M_CNT, M_SCT, M_DD
  } mode_t;

  // Vertex picks for slots vw, ab, cd, av, vb, cw, wd out of v, w, a, b, c, d.
  localparam logic [2:0] SLOT_X [SLOTS_PER_OP] = '{3'd0, 3'd2, 3'd4, 3'd2, 3'd0, 3'd4, 3'd1};
  localparam logic [2:0] SLOT_Y [SLOTS_PER_OP] = '{3'd1, 3'd3, 3'd5, 3'd0, 3'd3, 3'd1, 3'd5};

endpackage

### rtl/esd_ram.sv
// Simple dual-port synchronous RAM with registered read.
module esd_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/edge_sort_dedup_indexer.sv
// Top level of the edge sort, deduplicate and index block.
// A load beat stores seven normalized slot edges, one per cycle, and then answers.
// Finish runs a two-pass bucket sort held in RAM: each pass clears 2^VERTEX_BITS+1 buckets,
// makes one read-modify-write per stored edge to count, a prefix step for each bucket above
// zero, and one step per edge to scatter; deduplication then visits each edge in sorted order
// and the MAX_OPS*7+1 short flags are cleared. Slot reads pass through states S_Q_A, S_Q_B
// and S_Q_C, edge reads and flag updates through S_Q_B and S_Q_C; errors answer straight
// from idle. Every item gives one result, shown for one cycle with out_strobe; the receiver
// cannot stall it. busy is high while an item is being worked on, and start is taken only
// while busy is low.
module edge_sort_dedup_indexer #(
  parameter int MAX_OPS     = esd_pkg::MAX_OPS_DEF,
  parameter int VERTEX_BITS = esd_pkg::VERTEX_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [esd_pkg::CMD_W-1:0]   in_cmd,
  input  logic [esd_pkg::OPI_W-1:0]   in_op_index,
  input  logic [esd_pkg::SLOT_W-1:0]  in_slot,
  input  logic [esd_pkg::EIDX_W-1:0]  in_edge_index,
  input  logic [esd_pkg::VTX_W-1:0]   in_first_v,
  input  logic [esd_pkg::VTX_W-1:0]   in_first_w,
  input  logic [esd_pkg::VTX_W-1:0]   in_second_a,
  input  logic [esd_pkg::VTX_W-1:0]   in_second_b,
  input  logic [esd_pkg::VTX_W-1:0]   in_third_c,
  input  logic [esd_pkg::VTX_W-1:0]   in_third_d,
  output logic                        out_strobe,
  output logic [esd_pkg::STAT_W-1:0]  out_status,
  output logic [esd_pkg::CNT_W-1:0]   out_edge_count,
  output logic [esd_pkg::EIDX_W-1:0]  out_edge_number,
  output logic [esd_pkg::VTX_W-1:0]   out_end_low,
  output logic [esd_pkg::VTX_W-1:0]   out_end_high,
  output logic                        out_is_short,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [esd_pkg::VTX_W-1:0]   cfg_max_vertex
);
  import esd_pkg::*;

  localparam int NSLOT = MAX_OPS * SLOTS_PER_OP;
  localparam int SW    = $clog2(NSLOT);
  localparam int NW    = $clog2(NSLOT + 1);
  localparam int OW    = $clog2(MAX_OPS + 1);
  localparam int VB    = VERTEX_BITS;
  localparam int NVERT = 1 << VB;
  localparam int BW    = VB + 1;
  localparam int EW    = 2 * VB;
  localparam int JW    = ((NW > BW) ? NW : BW) + 1;

  state_t            state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic              pass_r, pass_nxt;
  logic [NW-1:0]     i_r, i_nxt;
  logic [JW-1:0]     j_r, j_nxt;
  logic [2:0]        k_r, k_nxt;
  logic [SW-1:0]     s_r, s_nxt;
  logic [BW-1:0]     ba_r, ba_nxt;
  logic [NW-1:0]     sum_r, sum_nxt;
  logic [NW-1:0]     cnt_r, cnt_nxt;
  logic [EW-1:0]     prev_r, prev_nxt;
  logic [NW-1:0]     base_r, base_nxt;
  logic [OW-1:0]     opc_r, opc_nxt;
  logic [NW-1:0]     dcount_r, dcount_nxt;
  logic              fin_r, fin_nxt;
  logic [VTX_W-1:0]  maxv_r;
  logic [VB-1:0]     v_r [6];
  logic [VB-1:0]     v_nxt [6];
  cmd_t              cmd_r, cmd_nxt;
  logic [NW-1:0]     idx_r, idx_nxt;

  logic              strobe_r, strobe_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic [CNT_W-1:0]  ecnt_r, ecnt_nxt;
  logic [EIDX_W-1:0] enum_r, enum_nxt;
  logic [VTX_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic              sh_r, sh_nxt;

  logic slot_we;  logic [SW-1:0] slot_wa, slot_ra; logic [EW-1:0] slot_wd, slot_q;
  logic num_we;   logic [SW-1:0] num_wa, num_ra;   logic [NW-1:0] num_wd, num_q;
  logic dist_we;  logic [NW-1:0] dist_wa, dist_ra; logic [EW-1:0] dist_wd, dist_q;
  logic flag_we;  logic [NW-1:0] flag_wa, flag_ra; logic flag_wd, flag_q;
  logic bkt_we;   logic [BW-1:0] bkt_wa, bkt_ra;   logic [NW-1:0] bkt_wd, bkt_q;
  logic orda_we, ordb_we; logic [SW-1:0] ord_wa, ord_ra, ord_wd, orda_q, ordb_q;

  logic [VTX_W-1:0]  vin [6];
  logic              vbad;
  logic [SW-1:0]     qs;
  logic [VB-1:0]     ex, ey, key;
  logic [SW-1:0]     ls;
  logic [SW-1:0]     ord_q;
  logic              is_new;
  logic [NW-1:0]     cnt_inc;

  esd_ram #(.DEPTH(NSLOT), .WIDTH(EW)) u_slot (
    .clk, .we(slot_we), .waddr(slot_wa), .wdata(slot_wd), .raddr(slot_ra), .rdata(slot_q));
  esd_ram #(.DEPTH(NSLOT), .WIDTH(NW)) u_num (
    .clk, .we(num_we), .waddr(num_wa), .wdata(num_wd), .raddr(num_ra), .rdata(num_q));
  esd_ram #(.DEPTH(NSLOT + 1), .WIDTH(EW)) u_dist (
    .clk, .we(dist_we), .waddr(dist_wa), .wdata(dist_wd), .raddr(dist_ra), .rdata(dist_q));
  esd_ram #(.DEPTH(NSLOT + 1), .WIDTH(1)) u_flag (
    .clk, .we(flag_we), .waddr(flag_wa), .wdata(flag_wd), .raddr(flag_ra), .rdata(flag_q));
  esd_ram #(.DEPTH(NVERT + 1), .WIDTH(NW)) u_bkt (
    .clk, .we(bkt_we), .waddr(bkt_wa), .wdata(bkt_wd), .raddr(bkt_ra), .rdata(bkt_q));
  esd_ram #(.DEPTH(NSLOT), .WIDTH(SW)) u_orda (
    .clk, .we(orda_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata(orda_q));
  esd_ram #(.DEPTH(NSLOT), .WIDTH(SW)) u_ordb (
    .clk, .we(ordb_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata(ordb_q));

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;

  assign out_strobe      = strobe_r;
  assign out_status      = stat_r;
  assign out_edge_count  = ecnt_r;
  assign out_edge_number = enum_r;
  assign out_end_low     = lo_r;
  assign out_end_high    = hi_r;
  assign out_is_short    = sh_r;

  always_comb begin
    vin[0] = in_first_v;
    vin[1] = in_first_w;
    vin[2] = in_second_a;
    vin[3] = in_second_b;
    vin[4] = in_third_c;
    vin[5] = in_third_d;
    vbad = 1'b0;
    for (int n = 0; n < 6; n++) begin
      if (vin[n] > maxv_r || 32'(vin[n]) > 32'(NVERT - 1)) begin
        vbad = 1'b1;
      end
    end
  end

  assign qs = SW'(32'(in_op_index) * SLOTS_PER_OP + 32'(in_slot));

  // Slot edge of the current load step, smaller vertex first.
  always_comb begin
    logic [VB-1:0] x, y;
    x = v_r[SLOT_X[k_r]];
    y = v_r[SLOT_Y[k_r]];
    ex = (x > y) ? y : x;
    ey = (x > y) ? x : y;
  end

  assign ord_q   = (mode_r == M_DD) ? ordb_q : orda_q;
  assign ls      = (mode_r != M_DD && !pass_r) ? SW'(i_r) : ord_q;
  assign key     = pass_r ? slot_q[EW-1:VB] : slot_q[VB-1:0];
  assign is_new  = (cnt_r == '0) || (slot_q != prev_r);
  assign cnt_inc = cnt_r + NW'(is_new);

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    pass_nxt   = pass_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    s_nxt      = s_r;
    ba_nxt     = ba_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    prev_nxt   = prev_r;
    base_nxt   = base_r;
    opc_nxt    = opc_r;
    dcount_nxt = dcount_r;
    fin_nxt    = fin_r;
    v_nxt      = v_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;

    strobe_nxt = 1'b0;
    stat_nxt   = ST_OK;
    ecnt_nxt   = CNT_W'(dcount_r);
    enum_nxt   = '0;
    lo_nxt     = '0;
    hi_nxt     = '0;
    sh_nxt     = 1'b0;

    slot_we = 1'b0; slot_wa = SW'(base_r + NW'(k_r)); slot_wd = {ex, ey}; slot_ra = ls;
    num_we  = 1'b0; num_wa  = s_r; num_wd = cnt_inc; num_ra = s_r;
    dist_we = 1'b0; dist_wa = cnt_inc; dist_wd = slot_q; dist_ra = idx_r;
    flag_we = 1'b0; flag_wa = idx_r; flag_wd = 1'b0; flag_ra = idx_r;
    bkt_we  = 1'b0; bkt_wa  = ba_r; bkt_wd = bkt_q + NW'(1); bkt_ra = j_r[BW-1:0];
    orda_we = 1'b0; ordb_we = 1'b0;
    ord_wa  = bkt_q[SW-1:0]; ord_wd = s_r; ord_ra = i_r[SW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = cmd_t'(in_cmd);
          case (in_cmd)
            CMD_LOAD: begin
              if (fin_r || 32'(opc_r) >= 32'(MAX_OPS)) begin
                strobe_nxt = 1'b1;
                stat_nxt   = ST_FULL;
              end else if (vbad) begin
                strobe_nxt = 1'b1;
                stat_nxt   = ST_BAD;
              end else begin
                for (int n = 0; n < 6; n++) begin
                  v_nxt[n] = VB'(vin[n]);
                end
                k_nxt     = '0;
                state_nxt = S_LOAD;
              end
            end
            CMD_FINISH: begin
              pass_nxt  = 1'b0;
              j_nxt     = '0;
              state_nxt = S_BCLR;
            end
            CMD_READ_SLOT: begin
              if (!fin_r) begin
                strobe_nxt = 1'b1;
                stat_nxt   = ST_FULL;
              end else if (32'(in_op_index) >= 32'(opc_r)
                           || 32'(in_slot) >= 32'(SLOTS_PER_OP)) begin
                strobe_nxt = 1'b1;
                stat_nxt   = ST_BAD;
              end else begin
                s_nxt     = qs;
                state_nxt = S_Q_A;
              end
            end
            CMD_SET_SHORT, CMD_CLR_SHORT, CMD_READ_EDGE: begin
              if (!fin_r) begin
                strobe_nxt = 1'b1;
                stat_nxt   = ST_FULL;
              end else if (in_edge_index == '0
                           || 32'(in_edge_index) > 32'(dcount_r)) begin
                strobe_nxt = 1'b1;
                stat_nxt   = ST_BAD;
              end else begin
                idx_nxt   = NW'(in_edge_index);
                state_nxt = S_Q_B;
              end
            end
            default: begin
              strobe_nxt = 1'b1;
              stat_nxt   = ST_BAD;
            end
          endcase
        end
      end
      S_LOAD: begin
        slot_we = 1'b1;
        k_nxt   = k_r + 3'd1;
        if (32'(k_r) == SLOTS_PER_OP - 1) begin
          opc_nxt    = opc_r + OW'(1);
          base_nxt   = base_r + NW'(SLOTS_PER_OP);
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_BCLR: begin
        bkt_we = 1'b1;
        bkt_wa = j_r[BW-1:0];
        bkt_wd = '0;
        j_nxt  = j_r + JW'(1);
        if (j_r == JW'(NVERT)) begin
          mode_nxt  = M_CNT;
          i_nxt     = '0;
          state_nxt = S_L_A;
        end
      end
      S_L_A: begin
        // Order memory read for this position is issued here.
        if (i_r == base_r) begin
          case (mode_r)
            M_CNT: begin
              j_nxt     = JW'(1);
              sum_nxt   = '0;
              state_nxt = S_PFX_A;
            end
            M_SCT: begin
              if (!pass_r) begin
                pass_nxt  = 1'b1;
                j_nxt     = '0;
                state_nxt = S_BCLR;
              end else begin
                mode_nxt  = M_DD;
                i_nxt     = '0;
                cnt_nxt   = '0;
                state_nxt = S_L_A;
              end
            end
            default: begin
              j_nxt     = '0;
              state_nxt = S_FCLR;
            end
          endcase
        end else begin
          state_nxt = S_L_B;
        end
      end
      S_L_B: begin
        s_nxt     = ls;
        state_nxt = S_L_C;
      end
      S_L_C: begin
        if (mode_r == M_DD) begin
          if (is_new) begin
            dist_we  = 1'b1;
            prev_nxt = slot_q;
          end
          num_we    = 1'b1;
          cnt_nxt   = cnt_inc;
          i_nxt     = i_r + NW'(1);
          state_nxt = S_L_A;
        end else begin
          ba_nxt    = (mode_r == M_CNT) ? BW'(key) + BW'(1) : BW'(key);
          bkt_ra    = ba_nxt;
          state_nxt = S_L_D;
        end
      end
      S_L_D: begin
        bkt_we = 1'b1;
        if (mode_r == M_SCT) begin
          orda_we = !pass_r;
          ordb_we = pass_r;
        end
        i_nxt     = i_r + NW'(1);
        state_nxt = S_L_A;
      end
      S_PFX_A: begin
        state_nxt = S_PFX_B;
      end
      S_PFX_B: begin
        sum_nxt = sum_r + bkt_q;
        bkt_we  = 1'b1;
        bkt_wa  = j_r[BW-1:0];
        bkt_wd  = sum_nxt;
        j_nxt   = j_r + JW'(1);
        if (j_r == JW'(NVERT)) begin
          mode_nxt  = M_SCT;
          i_nxt     = '0;
          state_nxt = S_L_A;
        end else begin
          state_nxt = S_PFX_A;
        end
      end
      S_FCLR: begin
        flag_we = 1'b1;
        flag_wa = j_r[NW-1:0];
        j_nxt   = j_r + JW'(1);
        if (j_r == JW'(NSLOT)) begin
          dcount_nxt = cnt_r;
          fin_nxt    = 1'b1;
          strobe_nxt = 1'b1;
          ecnt_nxt   = CNT_W'(cnt_r);
          state_nxt  = S_IDLE;
        end
      end
      S_Q_A: begin
        state_nxt = S_Q_B;
      end
      S_Q_B: begin
        if (cmd_r == CMD_READ_SLOT) begin
          idx_nxt = num_q;
        end
        dist_ra   = idx_nxt;
        flag_ra   = idx_nxt;
        state_nxt = S_Q_C;
      end
      S_Q_C: begin
        strobe_nxt = 1'b1;
        lo_nxt     = VTX_W'(dist_q[EW-1:VB]);
        hi_nxt     = VTX_W'(dist_q[VB-1:0]);
        case (cmd_r)
          CMD_SET_SHORT: begin
            flag_we = 1'b1;
            flag_wd = 1'b1;
            sh_nxt  = 1'b1;
          end
          CMD_CLR_SHORT: begin
            flag_we = 1'b1;
            sh_nxt  = 1'b0;
          end
          CMD_READ_SLOT: begin
            enum_nxt = EIDX_W'(idx_r);
            sh_nxt   = flag_q;
          end
          default: begin
            sh_nxt = flag_q;
          end
        endcase
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= M_CNT;
      pass_r   <= 1'b0;
      base_r   <= '0;
      opc_r    <= '0;
      dcount_r <= '0;
      fin_r    <= 1'b0;
      maxv_r   <= '1;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      pass_r   <= pass_nxt;
      base_r   <= base_nxt;
      opc_r    <= opc_nxt;
      dcount_r <= dcount_nxt;
      fin_r    <= fin_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        maxv_r <= cfg_max_vertex;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    s_r    <= s_nxt;
    ba_r   <= ba_nxt;
    sum_r  <= sum_nxt;
    cnt_r  <= cnt_nxt;
    prev_r <= prev_nxt;
    v_r    <= v_nxt;
    cmd_r  <= cmd_nxt;
    idx_r  <= idx_nxt;
    stat_r <= stat_nxt;
    ecnt_r <= ecnt_nxt;
    enum_r <= enum_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    sh_r   <= sh_nxt;
  end

  // A result beat always lands back in idle.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result beat while busy");

  // An accepted item either answers at once or starts work.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_strobe || busy)) else $error("accepted item dropped");

  // Error results report no edge.
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |->
      (out_end_low == '0 && out_end_high == '0 && out_is_short == 1'b0
       && out_edge_number == '0)) else $error("error result carries an edge");

endmodule

### tb/tb_edge_sort_dedup_indexer.sv
// Self-checking testbench for the edge sort, deduplicate and index block.
`timescale 1ns / 1ps

module tb_edge_sort_dedup_indexer;
  import esd_pkg::*;

  localparam int NUM_OPS   = 256;
  localparam int NUM_SLOTS = NUM_OPS * SLOTS_PER_OP;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [OPI_W-1:0]  op_index;
    logic [SLOT_W-1:0] slot;
    logic [EIDX_W-1:0] edge_index;
    logic [VTX_W-1:0]  vtx [6];
  } edge_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  edge_count;
    logic [EIDX_W-1:0] edge_number;
    logic [VTX_W-1:0]  end_low;
    logic [VTX_W-1:0]  end_high;
    logic              is_short;
  } edge_reply_t;

  class edge_table_sb;
    logic [VTX_W-1:0]  max_vertex = 10'd1023;
    logic [VTX_W-1:0]  slot_lo [NUM_SLOTS];
    logic [VTX_W-1:0]  slot_hi [NUM_SLOTS];
    logic [EIDX_W-1:0] slot_rank [NUM_SLOTS];
    logic [VTX_W-1:0]  uniq_lo [NUM_SLOTS+1];
    logic [VTX_W-1:0]  uniq_hi [NUM_SLOTS+1];
    bit                flag [NUM_SLOTS+1];
    int                op_count = 0;
    int                uniq_count = 0;
    bit                sorted = 0;
    edge_reply_t       pending [$];
    int                mismatches = 0;

    function void put_slot(int s, logic [VTX_W-1:0] x, logic [VTX_W-1:0] y);
      slot_lo[s] = (x > y) ? y : x;
      slot_hi[s] = (x > y) ? x : y;
    endfunction

    // Sorting by (low, high) and numbering distinct keys in order gives the
    // same ranks as the stable two-pass bucket sort.
    function void rank_edges();
      int rank_of [int];
      int k;
      int r;
      r = 0;
      for (int s = 0; s < op_count * SLOTS_PER_OP; s++)
        rank_of[slot_lo[s] * 1024 + slot_hi[s]] = 0;
      foreach (rank_of[key]) begin
        r++;
        rank_of[key] = r;
        uniq_lo[r] = VTX_W'(key / 1024);
        uniq_hi[r] = VTX_W'(key % 1024);
      end
      for (int s = 0; s < op_count * SLOTS_PER_OP; s++) begin
        k = slot_lo[s] * 1024 + slot_hi[s];
        slot_rank[s] = EIDX_W'(rank_of[k]);
      end
      uniq_count = r;
      foreach (flag[i]) flag[i] = 0;
      sorted = 1;
    endfunction

    function void note_input(edge_cmd_t c);
      edge_reply_t r;
      bit bad;
      int b;
      int s;
      r = '{default: '0};
      if (c.cmd == CMD_LOAD) begin
        bad = 0;
        foreach (c.vtx[k]) if (c.vtx[k] > max_vertex) bad = 1;
        if (sorted || op_count >= NUM_OPS) r.status = ST_FULL;
        else if (bad) r.status = ST_BAD;
        else begin
          b = op_count * SLOTS_PER_OP;
          put_slot(b + 0, c.vtx[0], c.vtx[1]);
          put_slot(b + 1, c.vtx[2], c.vtx[3]);
          put_slot(b + 2, c.vtx[4], c.vtx[5]);
          put_slot(b + 3, c.vtx[2], c.vtx[0]);
          put_slot(b + 4, c.vtx[0], c.vtx[3]);
          put_slot(b + 5, c.vtx[4], c.vtx[1]);
          put_slot(b + 6, c.vtx[1], c.vtx[5]);
          op_count++;
        end
      end else if (c.cmd == CMD_FINISH) begin
        rank_edges();
      end else if (c.cmd > CMD_READ_EDGE) begin
        r.status = ST_BAD;
      end else if (!sorted) begin
        r.status = ST_FULL;
      end else if (c.cmd == CMD_READ_SLOT) begin
        if (c.op_index >= op_count || c.slot >= SLOTS_PER_OP) r.status = ST_BAD;
        else begin
          s = c.op_index * SLOTS_PER_OP + c.slot;
          r.edge_number = slot_rank[s];
          r.end_low = uniq_lo[slot_rank[s]];
          r.end_high = uniq_hi[slot_rank[s]];
          r.is_short = flag[slot_rank[s]];
        end
      end else begin
        if (c.edge_index == 0 || c.edge_index > uniq_count) r.status = ST_BAD;
        else begin
          if (c.cmd == CMD_SET_SHORT) flag[c.edge_index] = 1;
          else if (c.cmd == CMD_CLR_SHORT) flag[c.edge_index] = 0;
          r.end_low = uniq_lo[c.edge_index];
          r.end_high = uniq_hi[c.edge_index];
          r.is_short = flag[c.edge_index];
        end
      end
      r.edge_count = CNT_W'(uniq_count);
      pending = {pending, r};
    endfunction

    function void check_result(edge_reply_t got);
      edge_reply_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat, status %0d", got.status);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp st=%0d cnt=%0d num=%0d lo=%0d hi=%0d sh=%0d,",
                    " got st=%0d cnt=%0d num=%0d lo=%0d hi=%0d sh=%0d"},
                   want.status, want.edge_count, want.edge_number, want.end_low,
                   want.end_high, want.is_short, got.status, got.edge_count,
                   got.edge_number, got.end_low, got.end_high, got.is_short);
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              start = 0;
  logic              busy;
  logic [CMD_W-1:0]  in_cmd = '0;
  logic [OPI_W-1:0]  in_op_index = '0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic [EIDX_W-1:0] in_edge_index = '0;
  logic [VTX_W-1:0]  in_first_v = '0, in_first_w = '0, in_second_a = '0;
  logic [VTX_W-1:0]  in_second_b = '0, in_third_c = '0, in_third_d = '0;
  logic              out_strobe;
  logic [STAT_W-1:0] out_status;
  logic [CNT_W-1:0]  out_edge_count;
  logic [EIDX_W-1:0] out_edge_number;
  logic [VTX_W-1:0]  out_end_low, out_end_high;
  logic              out_is_short;
  logic              cfg_valid = 0;
  logic              cfg_ready;
  logic [VTX_W-1:0]  cfg_max_vertex = '0;

  edge_table_sb sb = new();
  int sent = 0;
  int idle_pct = 0;

  edge_sort_dedup_indexer i_dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check_result('{out_status, out_edge_count, out_edge_number, out_end_low,
                        out_end_high, out_is_short});
  end

  task automatic send(edge_cmd_t c);
    // The idle share changes every hundred beats.
    case ((sent / 100) % 4)
      0: idle_pct = 0;
      1, 2: idle_pct = 53;
      default: idle_pct = 6;
    endcase
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= c.cmd;
    in_op_index <= c.op_index;
    in_slot <= c.slot;
    in_edge_index <= c.edge_index;
    in_first_v <= c.vtx[0];
    in_first_w <= c.vtx[1];
    in_second_a <= c.vtx[2];
    in_second_b <= c.vtx[3];
    in_third_c <= c.vtx[4];
    in_third_d <= c.vtx[5];
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(c);
    sent++;
  endtask

  task automatic set_max_vertex(logic [VTX_W-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_max_vertex <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.max_vertex = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic edge_cmd_t make_cmd(logic [CMD_W-1:0] cmd, int vmax);
    edge_cmd_t c;
    c.cmd = cmd;
    c.op_index = OPI_W'($urandom);
    c.slot = SLOT_W'($urandom);
    c.edge_index = EIDX_W'($urandom);
    foreach (c.vtx[k]) c.vtx[k] = VTX_W'($urandom_range(vmax));
    return c;
  endfunction

  task automatic load_ops(int count, int vmax);
    repeat (count) send(make_cmd(CMD_LOAD, vmax));
  endtask

  task automatic query_mix(int count);
    edge_cmd_t c;
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      c = make_cmd(CMD_READ_SLOT, 1023);
      if (pick < 35) begin
        if ($urandom_range(9) != 0) begin
          c.op_index = OPI_W'($urandom_range(sb.op_count - 1));
          c.slot = SLOT_W'($urandom_range(SLOTS_PER_OP - 1));
        end
      end else if (pick < 90) begin
        c.cmd = CMD_W'(CMD_SET_SHORT + $urandom_range(2));
        if ($urandom_range(9) != 0)
          c.edge_index = EIDX_W'($urandom_range(sb.uniq_count + 1));
      end else if (pick < 94) c.cmd = CMD_LOAD;
      else c.cmd = CMD_W'(3'd6 + $urandom_range(1));
      send(c);
    end
  endtask

  initial begin
    edge_cmd_t c;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Before any finish: reads and flag updates are refused, unknown codes are bad.
    for (int k = CMD_READ_SLOT; k <= 7; k++) send(make_cmd(CMD_W'(k), 1023));

    // Lowest vertex limit: all-zero load is taken, any nonzero vertex is bad.
    set_max_vertex(10'd0);
    send(make_cmd(CMD_LOAD, 0));
    for (int k = 0; k < 6; k++) begin
      c = make_cmd(CMD_LOAD, 0);
      c.vtx[k] = 10'd1;
      send(c);
    end
    set_max_vertex(10'd1023);
    c = make_cmd(CMD_LOAD, 0);
    foreach (c.vtx[k]) c.vtx[k] = 10'd1023;
    send(c);
    c.vtx = '{10'd1023, 10'd0, 10'd512, 10'd511, 10'd0, 10'd1023};
    send(c);
    c.vtx = '{10'd5, 10'd5, 10'd5, 10'd5, 10'd5, 10'd5};
    send(c);

    load_ops(60, 1023);
    set_max_vertex(10'd31);
    load_ops(80, 40);
    set_max_vertex(10'd1023);
    load_ops(140, 12);
    load_ops(4, 1023);

    send(make_cmd(CMD_FINISH, 1023));
    query_mix(200);
    set_max_vertex(10'd300);
    query_mix(150);
    // A second finish redoes the numbering and clears every short flag.
    send(make_cmd(CMD_FINISH, 1023));
    query_mix(150);
    set_max_vertex(10'd1023);
    send(make_cmd(CMD_FINISH, 1023));
    query_mix(60);

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #(64'd5_000_000 * 20);
    $display("tb: failure");
    $finish;
  end

endmodule
